// ----- design/hed_pkg.sv -----
// shared types, constants and the byte classifier of the character reference decoder
package hed_pkg;

   localparam int REF_WINDOW  = 10;
   localparam int PEND_DEPTH  = REF_WINDOW - 1;
   localparam int PEND_IDX_W  = $clog2(PEND_DEPTH);
   localparam int CNT_W       = $clog2(PEND_DEPTH + 1);
   localparam int RPL_DEPTH   = REF_WINDOW;
   localparam int RPL_IDX_W   = $clog2(RPL_DEPTH);
   localparam int RPL_W       = $clog2(RPL_DEPTH + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CP_W        = 21;
   localparam int NV_W        = CP_W + 4;

   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic       is_amp;
      logic       is_semi;
      logic       is_hash;
      logic       is_xmark;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] nibble;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     text_byte;
      byte_class_type cls;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      end_of_text;
   } item_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      logic           dig;
      logic           alpha;
      dig   = (b >= 8'h30) && (b <= 8'h39);
      alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
      c.is_amp   = (b == CH_AMP);
      c.is_semi  = (b == CH_SEMI);
      c.is_hash  = (b == CH_HASH);
      c.is_xmark = (b == CH_LX) || (b == CH_UX);
      c.is_dec   = dig;
      c.is_hex   = dig || alpha;
      if (dig) begin
         c.nibble = b[3:0];
      end else if (alpha) begin
         c.nibble = b[3:0] + 4'd9;
      end else begin
         c.nibble = 4'd0;
      end
      return c;
   endfunction

endpackage

// ----- design/hed_if.sv -----
// request and response channel interfaces of the character reference decoder
interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] decoded_byte;
   logic       final_byte;

   modport source (output valid, output decoded_byte, output final_byte, input ready);
   modport sink (input valid, input decoded_byte, input final_byte, output ready);
endinterface

// ----- design/hed_front.sv -----
// front end: takes requests, classifies each byte and queues it for the scanner
module hed_front import hed_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   hed_req_if.sink  req_port,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type                 fifo_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]   wr_ff, wr_in;
   logic [QUEUE_IDX_W-1:0]   rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                     push;
   logic                     pop;
   item_type                 new_item;

   assign req_port.ready = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push           = req_port.valid && req_port.ready;
   assign q_valid        = (cnt_ff != '0);
   assign pop            = q_pop && q_valid;
   assign q_item         = fifo_ff[rd_ff];

   always_comb begin
      new_item.entry.text_byte = req_port.text_byte;
      new_item.entry.cls       = classify(req_port.text_byte);
      new_item.end_of_text     = req_port.end_of_text;
   end

   // queue depth is a power of two, so the pointers wrap by themselves
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ----- design/hed_back.sv -----
// back end: reference scanner with replay buffer, utf-8 encoder and output register
module hed_back import hed_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      q_pop,
   hed_rsp_if.source rsp_port
);

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_UTF   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_LAST  = 2'd3;

   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_LG = 8'h67;
   localparam logic [7:0] CH_LL = 8'h6C;
   localparam logic [7:0] CH_LM = 8'h6D;
   localparam logic [7:0] CH_LN = 8'h6E;
   localparam logic [7:0] CH_LO = 8'h6F;
   localparam logic [7:0] CH_LP = 8'h70;
   localparam logic [7:0] CH_LQ = 8'h71;
   localparam logic [7:0] CH_LS = 8'h73;
   localparam logic [7:0] CH_LT_ = 8'h74;
   localparam logic [7:0] CH_LU = 8'h75;

   localparam logic [NV_W-1:0] CP_LIM = NV_W'(CP_MAX);

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last;
   } utf_type;

   function automatic utf_type utf8_encode(input logic [CP_W-1:0] cp);
      utf_type u;
      u.bytes = '0;
      if (cp < CP_W'(21'h80)) begin
         u.bytes[0] = cp[7:0];
         u.last     = 2'd0;
      end else if (cp < CP_W'(21'h800)) begin
         u.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         u.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
         u.last     = 2'd1;
      end else if (cp < CP_W'(21'h10000)) begin
         u.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         u.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         u.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
         u.last     = 2'd2;
      end else begin
         u.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
         u.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         u.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         u.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
         u.last     = 2'd3;
      end
      return u;
   endfunction

   entry_type          pend_ff [PEND_DEPTH];
   entry_type          rpl_ff [RPL_DEPTH];
   logic [1:0]         state_ff, state_in;
   logic               open_ff, open_in;
   logic [CNT_W-1:0]   pcnt_ff, pcnt_in;
   logic [CNT_W-1:0]   fcnt_ff, fcnt_in;
   logic [RPL_W-1:0]   rp_ff, rp_in;
   logic [RPL_W-1:0]   rlen_ff, rlen_in;
   logic [RPL_W-1:0]   opos_ff, opos_in;
   logic               eot_ff, eot_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [7:0]         hold_byte_ff, hold_byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_final_ff, rsp_final_in;
   logic               dec_ok_ff, dec_ok_in;
   logic [CP_W-1:0]    dec_val_ff, dec_val_in;
   logic               hex_ok_ff, hex_ok_in;
   logic [CP_W-1:0]    hex_val_ff, hex_val_in;
   utf_type            utf_ff;
   logic [1:0]         utf_idx_ff, utf_idx_in;

   logic               advance;
   logic               src_rpl;
   entry_type          cur;
   logic [NV_W-1:0]    dec_nv;
   logic [NV_W-1:0]    hex_nv;
   logic               name_hit;
   logic [7:0]         name_ch;
   logic               hex_mode;
   logic               num_hit;
   logic               ref_hit;
   logic [CP_W-1:0]    cp_sel;
   utf_type            utf_new;
   logic [CNT_W-1:0]   fcnt_m1;
   logic               have_byte;
   logic               eot_mode;
   logic               emit_v;
   logic [7:0]         emit_b;
   logic               pend_we;
   logic               rpl_copy;
   logic               utf_load;
   logic               finish_push;

   assign advance = !rsp_valid_ff || rsp_port.ready;
   assign src_rpl = (rp_ff != rlen_ff);
   assign cur     = src_rpl ? rpl_ff[rp_ff[RPL_IDX_W-1:0]] : q_item.entry;

   // running numeric values, built as bytes are held
   assign dec_nv = (NV_W'(dec_val_ff) << 3) + (NV_W'(dec_val_ff) << 1) + NV_W'(cur.cls.nibble);
   assign hex_nv = (NV_W'(hex_val_ff) << 4) + NV_W'(cur.cls.nibble);

   always_comb begin
      name_hit = 1'b1;
      name_ch  = CH_AMP;
      priority if (pcnt_ff == CNT_W'(3) && pend_ff[0].text_byte == CH_LA
                   && pend_ff[1].text_byte == CH_LM && pend_ff[2].text_byte == CH_LP) begin
         name_ch = CH_AMP;
      end else if (pcnt_ff == CNT_W'(2) && pend_ff[0].text_byte == CH_LL
                   && pend_ff[1].text_byte == CH_LT_) begin
         name_ch = CH_LT;
      end else if (pcnt_ff == CNT_W'(2) && pend_ff[0].text_byte == CH_LG
                   && pend_ff[1].text_byte == CH_LT_) begin
         name_ch = CH_GT;
      end else if (pcnt_ff == CNT_W'(4) && pend_ff[0].text_byte == CH_LQ
                   && pend_ff[1].text_byte == CH_LU && pend_ff[2].text_byte == CH_LO
                   && pend_ff[3].text_byte == CH_LT_) begin
         name_ch = CH_QUOT;
      end else if (pcnt_ff == CNT_W'(4) && pend_ff[0].text_byte == CH_LA
                   && pend_ff[1].text_byte == CH_LP && pend_ff[2].text_byte == CH_LO
                   && pend_ff[3].text_byte == CH_LS) begin
         name_ch = CH_APOS;
      end else if (pcnt_ff == CNT_W'(4) && pend_ff[0].text_byte == CH_LN
                   && pend_ff[1].text_byte == CH_LB && pend_ff[2].text_byte == CH_LS
                   && pend_ff[3].text_byte == CH_LP) begin
         name_ch = CH_SPACE;
      end else begin
         name_hit = 1'b0;
      end
   end

   assign hex_mode = (pcnt_ff > CNT_W'(2)) && pend_ff[1].cls.is_xmark;
   assign num_hit  = (pcnt_ff >= CNT_W'(2)) && pend_ff[0].cls.is_hash
                     && (hex_mode ? (hex_ok_ff && hex_val_ff != '0)
                                  : (dec_ok_ff && dec_val_ff != '0));
   assign ref_hit  = name_hit || num_hit;
   assign cp_sel   = name_hit ? CP_W'(name_ch) : (hex_mode ? hex_val_ff : dec_val_ff);
   assign utf_new  = utf8_encode(cp_sel);
   assign fcnt_m1  = fcnt_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      open_in       = open_ff;
      pcnt_in       = pcnt_ff;
      fcnt_in       = fcnt_ff;
      rp_in         = rp_ff;
      rlen_in       = rlen_ff;
      opos_in       = opos_ff;
      eot_in        = eot_ff;
      dec_ok_in     = dec_ok_ff;
      dec_val_in    = dec_val_ff;
      hex_ok_in     = hex_ok_ff;
      hex_val_in    = hex_val_ff;
      utf_idx_in    = utf_idx_ff;
      q_pop         = 1'b0;
      have_byte     = 1'b0;
      eot_mode      = eot_ff;
      emit_v        = 1'b0;
      emit_b        = '0;
      pend_we       = 1'b0;
      rpl_copy      = 1'b0;
      utf_load      = 1'b0;
      finish_push   = 1'b0;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_final_in  = rsp_final_ff;

      if (advance) begin
         unique case (state_ff)
            ST_RUN: begin
               if (src_rpl) begin
                  have_byte = 1'b1;
                  rp_in     = rp_ff + 1'b1;
               end else if (eot_ff) begin
                  if (open_ff) begin
                     state_in = ST_FLUSH;
                     fcnt_in  = '0;
                  end else begin
                     state_in = ST_LAST;
                  end
               end else if (q_valid) begin
                  have_byte = 1'b1;
                  q_pop     = 1'b1;
                  eot_in    = q_item.end_of_text;
                  eot_mode  = q_item.end_of_text;
               end
               if (have_byte) begin
                  if (!open_ff) begin
                     if (cur.cls.is_amp) begin
                        open_in = 1'b1;
                        pcnt_in = '0;
                        opos_in = rp_ff + 1'b1;
                     end else begin
                        emit_v = 1'b1;
                        emit_b = cur.text_byte;
                     end
                  end else if (cur.cls.is_semi && ref_hit) begin
                     utf_load   = 1'b1;
                     utf_idx_in = '0;
                     state_in   = ST_UTF;
                     open_in    = 1'b0;
                     pcnt_in    = '0;
                  end else if (!cur.cls.is_semi && pcnt_ff < CNT_W'(PEND_DEPTH)) begin
                     pend_we = 1'b1;
                     pcnt_in = pcnt_ff + 1'b1;
                     if (pcnt_ff == '0) begin
                        dec_ok_in  = 1'b1;
                        dec_val_in = '0;
                        hex_ok_in  = 1'b1;
                        hex_val_in = '0;
                     end else begin
                        if (!cur.cls.is_dec || dec_nv > CP_LIM) begin
                           dec_ok_in = 1'b0;
                        end
                        dec_val_in = dec_nv[CP_W-1:0];
                        if (pcnt_ff >= CNT_W'(2)) begin
                           if (!cur.cls.is_hex || hex_nv > CP_LIM) begin
                              hex_ok_in = 1'b0;
                           end
                           hex_val_in = hex_nv[CP_W-1:0];
                        end
                     end
                  end else begin
                     // failed reference: literal '&', then rescan what followed it
                     emit_v  = 1'b1;
                     emit_b  = CH_AMP;
                     open_in = 1'b0;
                     pcnt_in = '0;
                     if (src_rpl) begin
                        rp_in = opos_ff;
                     end else begin
                        rpl_copy = 1'b1;
                        rp_in    = '0;
                        rlen_in  = RPL_W'(pcnt_ff) + RPL_W'(1);
                     end
                  end
               end
            end
            ST_UTF: begin
               emit_v = 1'b1;
               emit_b = utf_ff.bytes[utf_idx_ff];
               if (utf_idx_ff == utf_ff.last) begin
                  state_in = ST_RUN;
               end else begin
                  utf_idx_in = utf_idx_ff + 1'b1;
               end
            end
            ST_FLUSH: begin
               emit_v = 1'b1;
               emit_b = (fcnt_ff == '0) ? CH_AMP : pend_ff[fcnt_m1[PEND_IDX_W-1:0]].text_byte;
               if (fcnt_ff == pcnt_ff) begin
                  state_in = ST_LAST;
               end else begin
                  fcnt_in = fcnt_ff + 1'b1;
               end
            end
            ST_LAST: begin
               finish_push   = 1'b1;
               state_in      = ST_RUN;
               eot_in        = 1'b0;
               open_in       = 1'b0;
               pcnt_in       = '0;
               hold_valid_in = 1'b0;
            end
            default: begin
               state_in = ST_RUN;
            end
         endcase

         // end-of-text bytes wait in the hold register so the last one can be marked
         if (finish_push) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = hold_byte_ff;
            rsp_final_in = 1'b1;
         end else if (emit_v) begin
            if (eot_mode) begin
               hold_valid_in = 1'b1;
               hold_byte_in  = emit_b;
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = hold_byte_ff;
                  rsp_final_in = 1'b0;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_b;
               rsp_final_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         open_ff       <= 1'b0;
         pcnt_ff       <= '0;
         rp_ff         <= '0;
         rlen_ff       <= '0;
         eot_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         pcnt_ff       <= pcnt_in;
         rp_ff         <= rp_in;
         rlen_ff       <= rlen_in;
         eot_ff        <= eot_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fcnt_ff      <= fcnt_in;
      opos_ff      <= opos_in;
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_final_ff <= rsp_final_in;
      dec_ok_ff    <= dec_ok_in;
      dec_val_ff   <= dec_val_in;
      hex_ok_ff    <= hex_ok_in;
      hex_val_ff   <= hex_val_in;
      utf_idx_ff   <= utf_idx_in;
      if (utf_load) begin
         utf_ff <= utf_new;
      end
      if (pend_we) begin
         pend_ff[pcnt_ff[PEND_IDX_W-1:0]] <= cur;
      end
      if (rpl_copy) begin
         for (int k = 0; k < PEND_DEPTH; k++) begin
            rpl_ff[k] <= pend_ff[k];
         end
         rpl_ff[RPL_IDX_W'(pcnt_ff)] <= cur;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.decoded_byte = rsp_byte_ff;
   assign rsp_port.final_byte   = rsp_final_ff;

endmodule

// ----- design/html_entity_decoder_core.sv -----
// top level of the html character reference decoder: front end, request queue, scanner
// path: a plain byte passes the request queue and the output register before it is offered
// throughput, while the output does not stall: one plain byte per cycle if one is queued;
// utf-8 bytes of a decoded reference, and a failed reference's replay of its held bytes and
// the failing byte (up to ten), one a cycle; end of text flushes '&' and any held bytes
// reset: synchronous, clears queue, scanner and output state; held bytes need no clearing
module html_entity_decoder_core import hed_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hed_req_if.sink   req_port,
   hed_rsp_if.source rsp_port
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   hed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   hed_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench of the html character reference decoder
`timescale 1ns / 1ps

module tb_top;
   import hed_pkg::*;

   localparam int MAX_DECODED = 16;
   localparam int TAIL_CYCLES = 40;

   typedef enum int {RX_HEAVY, TX_HEAVY, NO_IDLE} idle_mode_type;

   typedef struct {
      logic [7:0]    text_byte;
      logic          end_of_text;
      idle_mode_type mode;
      bit            drain_first;
   } text_request_type;

   typedef struct {
      logic [7:0] decoded_byte;
      logic       final_byte;
   } decoded_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_ready = 1'b0;
   logic       req_taken = 1'b0;

   hed_req_if req_bus ();
   hed_rsp_if rsp_bus ();

   assign req_bus.valid       = req_valid;
   assign req_bus.text_byte   = req_text_byte;
   assign req_bus.end_of_text = req_end_of_text;
   assign rsp_bus.ready       = rsp_ready;

   html_entity_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   text_request_type   text_requests[$];
   decoded_result_type expected_decoded[$];
   logic [7:0]         step_bytes[$];
   idle_mode_type      rx_mode = RX_HEAVY;
   idle_mode_type      build_mode = RX_HEAVY;
   bit                 build_drain = 1'b0;
   int                 mismatches = 0;

   // decoder state as the predictor sees it
   logic [7:0] held_ref_bytes [REF_WINDOW];
   int         held_count = 0;
   bit         ref_open = 1'b0;

   string entity_names [6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};
   string noise_chars = "#xX09afAFgz;&";

   always #1 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int idle_percent(input idle_mode_type mode, input bit receiver);
      case (mode)
         RX_HEAVY: return receiver ? 62 : 32;
         TX_HEAVY: return receiver ? 32 : 62;
         default:  return 0;
      endcase
   endfunction

   function automatic void emit_decoded(input logic [7:0] b);
      if (step_bytes.size() < MAX_DECODED) step_bytes.push_back(b);
   endfunction

   function automatic bit held_equals(input string name);
      int k;
      if (held_count != name.len()) return 1'b0;
      for (k = 0; k < held_count; k++) begin
         if (held_ref_bytes[k] != name[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // decodes the held reference text, emitting only on success
   function automatic bit try_reference();
      logic [31:0] cp;
      logic [7:0]  c;
      int          digit;
      int          k;
      bit          hex;
      cp = 32'd0;
      if (held_equals("amp")) begin emit_decoded(CH_AMP); return 1'b1; end
      if (held_equals("lt")) begin emit_decoded(CH_LT); return 1'b1; end
      if (held_equals("gt")) begin emit_decoded(CH_GT); return 1'b1; end
      if (held_equals("quot")) begin emit_decoded(CH_QUOT); return 1'b1; end
      if (held_equals("apos")) begin emit_decoded(CH_APOS); return 1'b1; end
      if (held_equals("nbsp")) begin emit_decoded(CH_SPACE); return 1'b1; end
      if (held_count < 2 || held_ref_bytes[0] != CH_HASH) return 1'b0;
      hex = held_count > 2 && (held_ref_bytes[1] == CH_LX || held_ref_bytes[1] == CH_UX);
      for (k = hex ? 2 : 1; k < held_count; k++) begin
         c = held_ref_bytes[k];
         if (c >= "0" && c <= "9") begin
            digit = c - "0";
         end else if (hex && c >= "a" && c <= "f") begin
            digit = c - "a" + 10;
         end else if (hex && c >= "A" && c <= "F") begin
            digit = c - "A" + 10;
         end else begin
            return 1'b0;
         end
         cp = hex ? cp * 16 + digit : cp * 10 + digit;
         if (cp > CP_MAX) return 1'b0;
      end
      if (cp == 0) return 1'b0;
      if (cp < 32'h80) begin
         emit_decoded(cp[7:0]);
      end else if (cp < 32'h800) begin
         emit_decoded(8'hC0 | cp[10:6]);
         emit_decoded(8'h80 | cp[5:0]);
      end else if (cp < 32'h10000) begin
         emit_decoded(8'hE0 | cp[15:12]);
         emit_decoded(8'h80 | cp[11:6]);
         emit_decoded(8'h80 | cp[5:0]);
      end else begin
         emit_decoded(8'hF0 | cp[20:18]);
         emit_decoded(8'h80 | cp[17:12]);
         emit_decoded(8'h80 | cp[11:6]);
         emit_decoded(8'h80 | cp[5:0]);
      end
      return 1'b1;
   endfunction

   function automatic void decode_text_byte(input logic [7:0] text_byte, input logic eot);
      logic [7:0]         rescan[$];
      logic [7:0]         replay[$];
      logic [7:0]         b;
      decoded_result_type res;
      int                 k;
      step_bytes.delete();
      rescan.push_back(text_byte);
      while (rescan.size() != 0) begin
         b = rescan.pop_front();
         if (!ref_open) begin
            if (b == CH_AMP) begin
               ref_open = 1'b1;
               held_count = 0;
            end else begin
               emit_decoded(b);
            end
         end else if (b == CH_SEMI && try_reference()) begin
            ref_open = 1'b0;
            held_count = 0;
         end else if (b != CH_SEMI && held_count < REF_WINDOW - 1) begin
            held_ref_bytes[held_count] = b;
            held_count++;
         end else begin
            // literal '&', then held bytes, this byte and the rest go round again
            emit_decoded(CH_AMP);
            replay.delete();
            for (k = 0; k < held_count; k++) replay.push_back(held_ref_bytes[k]);
            replay.push_back(b);
            while (rescan.size() != 0 && replay.size() < REF_WINDOW + 1) begin
               replay.push_back(rescan.pop_front());
            end
            rescan = replay;
            ref_open = 1'b0;
            held_count = 0;
         end
      end
      if (eot) begin
         if (ref_open) begin
            emit_decoded(CH_AMP);
            for (k = 0; k < held_count; k++) emit_decoded(held_ref_bytes[k]);
         end
         ref_open = 1'b0;
         held_count = 0;
      end
      for (k = 0; k < step_bytes.size(); k++) begin
         res.decoded_byte = step_bytes[k];
         res.final_byte   = eot && (k == step_bytes.size() - 1);
         expected_decoded.push_back(res);
      end
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic eot);
      text_request_type r;
      r.text_byte   = b;
      r.end_of_text = eot;
      r.mode        = build_mode;
      r.drain_first = build_drain;
      build_drain   = 1'b0;
      text_requests.push_back(r);
   endtask

   task automatic queue_text(input string s, input logic eot_last);
      int k;
      for (k = 0; k < s.len(); k++) queue_byte(s[k], eot_last && (k == s.len() - 1));
   endtask

   function automatic logic [31:0] pick_code_point();
      case ($urandom_range(7))
         0: return $urandom_range(32'h7F, 1);
         1: return $urandom_range(32'h7FF, 32'h80);
         2: return $urandom_range(32'hFFFF, 32'h800);
         3: return $urandom_range(32'hDFFF, 32'hD800);
         4: return $urandom_range(32'h10FFFF, 32'h10000);
         5: return 32'd0;
         6: return $urandom_range(32'h1FFFFF, 32'h110000);
         default: return $urandom_range(1) ? 32'h10FFFF : 32'h110000;
      endcase
   endfunction

   task automatic add_random_fragment();
      string frag;
      int    k;
      int    n;
      logic  eot_last;
      frag = "";
      eot_last = ($urandom_range(11) == 0);
      case ($urandom_range(9))
         0, 1: begin
            n = $urandom_range(2);
            for (k = n; k >= 0; k--) queue_byte(8'($urandom_range(255)), eot_last && k == 0);
         end
         2, 3: begin
            frag = entity_names[$urandom_range(5)];
            if ($urandom_range(4) == 0) begin
               k = $urandom_range(frag.len() - 1);
               frag[k] = frag[k] ^ 8'h20;
            end
            frag = {"&", frag};
            if ($urandom_range(7) != 0) frag = {frag, ";"};
         end
         4, 5: begin
            frag = $sformatf("%0d", pick_code_point());
            if ($urandom_range(5) == 0) frag = {"0", frag};
            frag = {"&#", frag, ";"};
         end
         6, 7: begin
            frag = $sformatf("%0h", pick_code_point());
            if ($urandom_range(5) == 0) frag = {"0", frag};
            for (k = 0; k < frag.len(); k++) begin
               if (frag[k] >= "a" && frag[k] <= "f" && $urandom_range(1)) frag[k] = frag[k] - 8'h20;
            end
            frag = $urandom_range(1) ? {"&#X", frag, ";"} : {"&#x", frag, ";"};
         end
         8: begin
            // broken reference: random run of reference-like characters
            n = $urandom_range(11);
            queue_byte(CH_AMP, eot_last && n == 0);
            for (k = 1; k <= n; k++) begin
               queue_byte(noise_chars[$urandom_range(noise_chars.len() - 1)], eot_last && k == n);
            end
         end
         default: begin
            // text ends in the middle of a reference
            if ($urandom_range(1)) frag = {"&", entity_names[$urandom_range(5)]};
            else frag = {"&#", $sformatf("%0d", pick_code_point())};
            queue_text(frag.substr(0, $urandom_range(frag.len() - 1)), 1'b1);
            frag = "";
         end
      endcase
      queue_text(frag, eot_last);
   endtask

   initial begin
      int target;
      // directed requests
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_text("&#X10FFFF;", 1'b0);
      queue_text("&#0;", 1'b0);
      queue_text("&amp&lt;", 1'b0);
      queue_text("&abcdefghijk", 1'b0);
      queue_text("&zz", 1'b1);
      target = text_requests.size();
      target += 40;
      while (text_requests.size() < target) add_random_fragment();
      build_mode  = TX_HEAVY;
      build_drain = 1'b1;
      target += 40;
      while (text_requests.size() < target) add_random_fragment();
      build_mode  = NO_IDLE;
      build_drain = 1'b1;
      target += 40;
      while (text_requests.size() < target) add_random_fragment();

      while (text_requests.size() != 0 || req_valid || expected_decoded.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

   always @(negedge clock) begin : drive_requests
      text_request_type next_request;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (text_requests.size() != 0
             && !(text_requests[0].drain_first && expected_decoded.size() != 0)
             && $urandom_range(99) >= idle_percent(text_requests[0].mode, 1'b0)) begin
            next_request = text_requests.pop_front();
            req_valid       <= 1'b1;
            req_text_byte   <= next_request.text_byte;
            req_end_of_text <= next_request.end_of_text;
            rx_mode         <= next_request.mode;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= idle_percent(rx_mode, 1'b1);
      end
   end

   always @(posedge clock) begin : check_responses
      decoded_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            decode_text_byte(req_bus.text_byte, req_bus.end_of_text);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_decoded.size() == 0) begin
               $error("decoded_byte: expected none, got %h", rsp_bus.decoded_byte);
               mismatches++;
            end else begin
               want = expected_decoded.pop_front();
               if (rsp_bus.decoded_byte !== want.decoded_byte) begin
                  $error("decoded_byte: expected %h, got %h", want.decoded_byte,
                         rsp_bus.decoded_byte);
                  mismatches++;
               end
               if (rsp_bus.final_byte !== want.final_byte) begin
                  $error("final_byte: expected %b, got %b", want.final_byte, rsp_bus.final_byte);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule
